// ===== src/pce_pkg.sv =====
// Package: shared types, constants and the CORDIC angle table for pose composition.
package pce_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int TRIG_ITER_DEF  = 16;
	localparam int ATAN_COUNT     = 24;
	localparam int CORDIC_FRAC    = 30;
	localparam int CW             = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] base_x;
		logic signed [31:0] base_y;
		logic signed [31:0] base_z;
		logic signed [15:0] base_roll;
		logic signed [15:0] base_pitch;
		logic signed [15:0] base_yaw;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
		logic signed [15:0] offset_roll;
		logic signed [15:0] offset_pitch;
		logic signed [15:0] offset_yaw;
	} pce_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [15:0] out_roll;
		logic signed [15:0] out_pitch;
		logic signed [15:0] out_yaw;
	} pce_out_t;

	function automatic logic signed [CW-1:0] atan_turn(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
			3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
			12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
			15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
			18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
			21: v = 32'h00000146; 22: v = 32'h000000A3; default: v = 32'h00000051;
		endcase
		return $signed({2'b00, v});
	endfunction

endpackage

// ===== src/pce_sincos.sv =====
// Pipelined CORDIC sine/cosine, one step per stage, with quadrant fold and rounding.
module pce_sincos import pce_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int TRIG_ITER = TRIG_ITER_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [15:0]                 angle,
	output logic signed [FRAC_BITS+1:0] sin_o,
	output logic signed [FRAC_BITS+1:0] cos_o
);
	localparam int N   = (TRIG_ITER < ATAN_COUNT) ? TRIG_ITER : ATAN_COUNT;
	localparam int SH  = CORDIC_FRAC - FRAC_BITS;
	localparam int OW  = FRAC_BITS + 2;

	logic signed [CW-1:0] x_s [N+1];
	logic signed [CW-1:0] y_s [N+1];
	logic signed [CW-1:0] z_s [N+1];
	logic [1:0]           q_s [N+1];

	logic [31:0] a32;
	logic [31:0] aq;
	logic [1:0]  q0;
	logic [31:0] zr;

	always_comb begin
		a32 = {angle, 16'h0000};
		aq  = a32 + 32'h20000000;
		q0  = aq[31:30];
		zr  = a32 - {q0, 30'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= CW'($signed(zr));
			q_s[0] <= q0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_turn(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_turn(i);
				end
			end
		end
	end

	logic signed [CW-1:0] xr, yr;
	logic signed [OW-1:0] cs, sn;

	always_comb begin
		xr = (x_s[N] + (CW'(1) <<< (SH - 1))) >>> SH;
		yr = (y_s[N] + (CW'(1) <<< (SH - 1))) >>> SH;
		cs = OW'(xr);
		sn = OW'(yr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[N])
				2'd0: begin cos_o <= cs;  sin_o <= sn;  end
				2'd1: begin cos_o <= -sn; sin_o <= cs;  end
				2'd2: begin cos_o <= -cs; sin_o <= -sn; end
				default: begin cos_o <= sn; sin_o <= -cs; end
			endcase
		end
	end
endmodule

// ===== src/pose_compose_euler_zyx.sv =====
// Pose composition: Z-Y-X rotation of the offset position plus base, angles summed.
// Pipeline stages, with N = TRIG_ITERATIONS capped at 24:
// one CORDIC load stage, N step stages, the quadrant fold and four arithmetic stages.
// Throughput: one pose per cycle while the output is not stalled; the CORDIC and multiply stages advance together.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
module pose_compose_euler_zyx import pce_pkg::*; #(
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pce_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output pce_out_t out_data
);
	localparam int N    = (TRIG_ITERATIONS < ATAN_COUNT) ? TRIG_ITERATIONS : ATAN_COUNT;
	localparam int TW   = FRAC_BITS + 2;        // trig and matrix entry width
	localparam int PW   = 2 * TW;
	localparam int LAT  = N + 2;                // input to registered trig
	localparam int AW   = 32 + TW + 3;          // accumulator width
	localparam int RH   = 1 << (FRAC_BITS - 1);

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// valid and payload delay line across the CORDIC stages
	logic     vld_d [LAT];
	pce_in_t  dat_d [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_d[k] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= in_valid;
			for (int k = 1; k < LAT; k++) vld_d[k] <= vld_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_d[0] <= in_data;
			for (int k = 1; k < LAT; k++) dat_d[k] <= dat_d[k-1];
		end
	end

	logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;

	pce_sincos #(.FRAC_BITS(FRAC_BITS), .TRIG_ITER(TRIG_ITERATIONS)) u_roll (
		.clk(clk), .en(en), .angle(in_data.base_roll), .sin_o(sx), .cos_o(cx));
	pce_sincos #(.FRAC_BITS(FRAC_BITS), .TRIG_ITER(TRIG_ITERATIONS)) u_pitch (
		.clk(clk), .en(en), .angle(in_data.base_pitch), .sin_o(sy), .cos_o(cy));
	pce_sincos #(.FRAC_BITS(FRAC_BITS), .TRIG_ITER(TRIG_ITERATIONS)) u_yaw (
		.clk(clk), .en(en), .angle(in_data.base_yaw), .sin_o(sz), .cos_o(cz));

	function automatic logic signed [TW-1:0] fmul(
		input logic signed [TW-1:0] a, input logic signed [TW-1:0] b);
		logic signed [PW-1:0] p;
		p = PW'(a) * PW'(b) + PW'(RH);
		return TW'(p >>> FRAC_BITS);
	endfunction

	// stage 1: pairwise trig products
	logic signed [TW-1:0] czsy_s1, szsy_s1, sx_s1, cx_s1, sy_s1;
	logic signed [TW-1:0] r00_s1, r10_s1, r21_s1, r22_s1;
	logic signed [TW-1:0] szcx_s1, szsx_s1, czcx_s1, czsx_s1;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	pce_in_t dat_s1, dat_s2, dat_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			czsy_s1 <= fmul(cz, sy);
			szsy_s1 <= fmul(sz, sy);
			r00_s1  <= fmul(cz, cy);
			r10_s1  <= fmul(sz, cy);
			r21_s1  <= fmul(cy, sx);
			r22_s1  <= fmul(cy, cx);
			szcx_s1 <= fmul(sz, cx);
			szsx_s1 <= fmul(sz, sx);
			czcx_s1 <= fmul(cz, cx);
			czsx_s1 <= fmul(cz, sx);
			sx_s1 <= sx; cx_s1 <= cx; sy_s1 <= sy;
			dat_s1 <= dat_d[LAT-1];
		end
	end

	// stage 2: triple products and matrix entries
	logic signed [TW-1:0] m_s2 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			m_s2[0] <= r00_s1;
			m_s2[1] <= fmul(czsy_s1, sx_s1) - szcx_s1;
			m_s2[2] <= fmul(czsy_s1, cx_s1) + szsx_s1;
			m_s2[3] <= r10_s1;
			m_s2[4] <= fmul(szsy_s1, sx_s1) + czcx_s1;
			m_s2[5] <= fmul(szsy_s1, cx_s1) - czsx_s1;
			m_s2[6] <= -sy_s1;
			m_s2[7] <= r21_s1;
			m_s2[8] <= r22_s1;
			dat_s2 <= dat_s1;
		end
	end

	// stage 3: nine products
	logic signed [TW+31:0] p_s3 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				p_s3[3*r]   <= (TW+32)'(m_s2[3*r])   * (TW+32)'(dat_s2.offset_x);
				p_s3[3*r+1] <= (TW+32)'(m_s2[3*r+1]) * (TW+32)'(dat_s2.offset_y);
				p_s3[3*r+2] <= (TW+32)'(m_s2[3*r+2]) * (TW+32)'(dat_s2.offset_z);
			end
			dat_s3 <= dat_s2;
		end
	end

	// stage 4: sum, round, saturate; angle sums
	function automatic logic signed [31:0] axis_sum(
		input logic signed [TW+31:0] a, input logic signed [TW+31:0] b,
		input logic signed [TW+31:0] c, input logic signed [31:0] base);
		logic signed [AW-1:0] acc;
		logic signed [AW-1:0] v;
		acc = AW'(a) + AW'(b) + AW'(c) + (AW'(base) <<< FRAC_BITS) + AW'(RH);
		v   = acc >>> FRAC_BITS;
		if (v > AW'(32'sh7FFFFFFF))       return 32'sh7FFFFFFF;
		else if (v < -AW'(33'sh80000000)) return 32'sh80000000;
		else                              return v[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.out_x <= axis_sum(p_s3[0], p_s3[1], p_s3[2], dat_s3.base_x);
			out_data.out_y <= axis_sum(p_s3[3], p_s3[4], p_s3[5], dat_s3.base_y);
			out_data.out_z <= axis_sum(p_s3[6], p_s3[7], p_s3[8], dat_s3.base_z);
			out_data.out_roll  <= dat_s3.base_roll  + dat_s3.offset_roll;
			out_data.out_pitch <= dat_s3.base_pitch + dat_s3.offset_pitch;
			out_data.out_yaw   <= dat_s3.base_yaw   + dat_s3.offset_yaw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_d[LAT-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end
	assign out_valid = vld_s4;

	// stalled output holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	// pipeline only moves when the output is free
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready disagrees with output state");
	// an item in the last stage reaches the output when the pipe advances
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && en |=> out_valid)
		else $error("item lost at output stage");
	// angle sums wrap
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && en |=> out_data.out_yaw == $past(dat_s3.base_yaw + dat_s3.offset_yaw))
		else $error("yaw sum mismatch");
endmodule

// ===== bench/pose_compose_euler_zyx_tb.sv =====
// Testbench for pose_compose_euler_zyx: self-checking against a bit-exact pose predictor.
module pose_compose_euler_zyx_tb import pce_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam int NITER = 16;
	localparam int LATENCY = NITER + 5;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	pce_in_t in_data;
	logic out_valid;
	logic out_ready;
	pce_out_t out_data;

	pce_out_t pose_q[$];
	int errors = 0;
	longint cycles = 0;
	bit stall_enable = 1;

	pose_compose_euler_zyx #(.FRAC_BITS(FB), .TRIG_ITERATIONS(NITER)) dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		if (s == 0)
			return v;
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint fix_mul(longint a, longint b);
		return rnd_shift(a * b, FB);
	endfunction

	function automatic void trig(logic [15:0] ang, output longint sn, output longint cs);
		logic [31:0] a;
		logic [1:0] quad;
		logic [31:0] res;
		longint z, x, y, dx, dy, c0, s0;
		a = {ang, 16'h0};
		quad = 2'((a + 32'h20000000) >> 30);
		res = a - {quad, 30'h0};
		z = longint'($signed(res));
		x = 652032874;
		y = 0;
		for (int i = 0; i < NITER && i < 24; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_turn(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_turn(i));
			end
		end
		c0 = rnd_shift(x, 30 - FB);
		s0 = rnd_shift(y, 30 - FB);
		case (quad)
			2'd0: begin cs = c0; sn = s0; end
			2'd1: begin cs = -s0; sn = c0; end
			2'd2: begin cs = -c0; sn = -s0; end
			default: begin cs = s0; sn = -c0; end
		endcase
	endfunction

	function automatic logic signed [31:0] rotate_axis(longint r0, longint r1, longint r2,
			longint o0, longint o1, longint o2, longint b);
		longint acc, v;
		acc = r0 * o0 + r1 * o1 + r2 * o2 + b * (longint'(1) << FB);
		v = rnd_shift(acc, FB);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return 32'(v);
	endfunction

	function automatic pce_out_t compose_pose(pce_in_t p);
		pce_out_t r;
		longint sx, cx, sy, cy, sz, cz, czsy, szsy, ox, oy, oz;
		trig(p.base_roll, sx, cx);
		trig(p.base_pitch, sy, cy);
		trig(p.base_yaw, sz, cz);
		czsy = fix_mul(cz, sy);
		szsy = fix_mul(sz, sy);
		ox = p.offset_x; oy = p.offset_y; oz = p.offset_z;
		r.out_x = rotate_axis(fix_mul(cz, cy), fix_mul(czsy, sx) - fix_mul(sz, cx),
			fix_mul(czsy, cx) + fix_mul(sz, sx), ox, oy, oz, p.base_x);
		r.out_y = rotate_axis(fix_mul(sz, cy), fix_mul(szsy, sx) + fix_mul(cz, cx),
			fix_mul(szsy, cx) - fix_mul(cz, sx), ox, oy, oz, p.base_y);
		r.out_z = rotate_axis(-sy, fix_mul(cy, sx), fix_mul(cy, cx), ox, oy, oz, p.base_z);
		r.out_roll = p.base_roll + p.offset_roll;
		r.out_pitch = p.base_pitch + p.offset_pitch;
		r.out_yaw = p.base_yaw + p.offset_yaw;
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// Receiver: random stall, check each transfer against the oldest prediction.
	initial begin
		pce_out_t want;
		int hold;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!stall_enable || hold == 0) begin
				out_ready <= 1;
				hold = gap_len();
			end else begin
				out_ready <= 0;
				hold--;
			end
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pose_q.size() == 0) begin
					errors++;
					$display("unexpected transfer at cycle %0d", cycles);
				end else begin
					want = pose_q.pop_front();
					if (out_data.out_x !== want.out_x)
						report_mismatch("out_x", out_data.out_x, want.out_x);
					if (out_data.out_y !== want.out_y)
						report_mismatch("out_y", out_data.out_y, want.out_y);
					if (out_data.out_z !== want.out_z)
						report_mismatch("out_z", out_data.out_z, want.out_z);
					if (out_data.out_roll !== want.out_roll)
						report_mismatch("out_roll", out_data.out_roll, want.out_roll);
					if (out_data.out_pitch !== want.out_pitch)
						report_mismatch("out_pitch", out_data.out_pitch, want.out_pitch);
					if (out_data.out_yaw !== want.out_yaw)
						report_mismatch("out_yaw", out_data.out_yaw, want.out_yaw);
				end
			end
		end
	end

	// Drive one pose at the falling edge and hold until the transfer.
	// Valid stays high after the transfer so the next pose can follow in the next cycle.
	task automatic send_pose(pce_in_t p, bit idle);
		int gap;
		gap = idle ? gap_len() : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 0;
		end
		@(negedge clk);
		in_valid <= 1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		pose_q.push_back(compose_pose(p));
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_ang();
		case ($urandom_range(0, 5))
			0: return 16'(16'h2000 * $urandom_range(0, 7) + $urandom_range(0, 2) - 1);
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic pce_in_t rand_pose();
		pce_in_t p;
		p.base_x = rand_pos(); p.base_y = rand_pos(); p.base_z = rand_pos();
		p.offset_x = rand_pos(); p.offset_y = rand_pos(); p.offset_z = rand_pos();
		p.base_roll = rand_ang(); p.base_pitch = rand_ang(); p.base_yaw = rand_ang();
		p.offset_roll = rand_ang(); p.offset_pitch = rand_ang(); p.offset_yaw = rand_ang();
		return p;
	endfunction

	// Drop valid, then hold until every expected result has come.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 0;
		while (pose_q.size() != 0)
			@(posedge clk);
	endtask

	// Identity pose, full-scale fields, quadrant edges, wrapping angle sums, full-scale offsets and an all-ones pose.
	task automatic test_directed();
		pce_in_t p;
		logic [15:0] ang;
		p = '0;
		send_pose(p, 0);
		p = {{3{32'h7FFFFFFF}}, {3{16'h7FFF}}, {3{32'h7FFFFFFF}}, {3{16'h7FFF}}};
		send_pose(p, 0);
		p = {{3{32'h80000000}}, {3{16'h8000}}, {3{32'h80000000}}, {3{16'h8000}}};
		send_pose(p, 0);
		p = {{3{32'h7FFFFFFF}}, {3{16'h0000}}, {3{32'h7FFFFFFF}}, {3{16'hFFFF}}};
		send_pose(p, 0);
		p = {{3{32'h80000000}}, {3{16'h0000}}, {3{32'h80000000}}, {3{16'h0001}}};
		send_pose(p, 0);
		for (int k = 0; k < 8; k++) begin
			ang = 16'(k * 16'h2000);
			p = '0;
			p.base_x = 32'h00010000; p.offset_x = 32'h00010000;
			p.offset_y = 32'h00020000; p.offset_z = 32'hFFFD0000;
			p.base_roll = ang; p.base_pitch = ang - 16'h1; p.base_yaw = ang + 16'h1;
			send_pose(p, 0);
		end
		for (int k = 0; k < 8; k++)
			send_pose({{3{32'($urandom)}}, 16'($urandom), 16'($urandom), 16'($urandom),
				{3{32'h7FFFFFFF}}, 16'($urandom), 16'($urandom), 16'($urandom)}, 1);
		p = {{3{32'hFFFFFFFF}}, {3{16'hFFFF}}, {3{32'hFFFFFFFF}}, {3{16'hFFFF}}};
		send_pose(p, 0);
	endtask

	// Back-to-back transfers with the receiver always ready.
	task automatic test_full_rate();
		stall_enable = 0;
		for (int k = 0; k < 100; k++)
			send_pose(rand_pose(), 0);
		wait_drained();
		stall_enable = 1;
	endtask

	// Random poses with random gaps on both sides.
	task automatic test_random();
		for (int k = 0; k < 900; k++) begin
			send_pose(rand_pose(), k % 5 != 0);
			// hold until the pipeline empties now and then
			if (k % 300 == 150)
				wait_drained();
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_full_rate();
		test_random();
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/pce_pkg.sv
src/pce_sincos.sv
src/pose_compose_euler_zyx.sv
bench/pose_compose_euler_zyx_tb.sv
